// ===== rtl/core/ffid_pkg.sv =====
// Shared constants, codes and types of the first-free identifier allocator.
package ffid_pkg;

   localparam int ID_W         = 16;
   localparam int WORD_W       = 32;
   localparam int BIT_W        = $clog2(WORD_W);
   localparam int ID_COUNT_DEF = 4096;

   localparam logic [ID_W-1:0] BASE_RESET = 16'd300;

   localparam logic [1:0] CMD_CLEAR   = 2'd0;
   localparam logic [1:0] CMD_ALLOC   = 2'd1;
   localparam logic [1:0] CMD_RELEASE = 2'd2;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_NONE_FREE = 2'd1;
   localparam logic [1:0] ST_INVALID   = 2'd2;

   typedef struct packed {
      logic              found;
      logic [BIT_W-1:0]  idx;
      logic [WORD_W-1:0] onehot;
      logic              full_after;
   } ffid_find_type;

endpackage

// ===== rtl/core/ffid_ram.sv =====
// Generic single-port RAM with registered read data.
module ffid_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] addr,
   input  logic [WIDTH-1:0]  wdata,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/core/ffid_find.sv =====
// Lowest-clear-bit search over one bitmap word.
module ffid_find
   import ffid_pkg::*;
(
   input  logic [WORD_W-1:0] word,
   output ffid_find_type     result
);

   logic [WORD_W-1:0] onehot;
   logic [BIT_W-1:0]  idx;

   // Adding one ripples through the low ones and lands on the lowest zero.
   assign onehot = ~word & (word + WORD_W'(1));

   always_comb begin
      idx = '0;
      for (int b = 0; b < BIT_W; b++) begin
         for (int i = 0; i < WORD_W; i++) begin
            if (((i >> b) & 1) == 1) begin
               idx[b] = idx[b] | onehot[i];
            end
         end
      end
   end

   assign result.found      = ~&word;
   assign result.idx        = idx;
   assign result.onehot     = onehot;
   assign result.full_after = &(word | onehot);

endmodule

// ===== rtl/core/first_free_id_allocator.sv =====
// Top level of the first-free identifier allocator over a word-wide bitmap.
//
// The pool of ID_COUNT identifiers starts at base_id and is kept as a bitmap of
// 32-bit words in one RAM, ID_COUNT/32 words (128 by default). After reset the
// block sweeps zeros through that RAM, one word a cycle, and takes no item until
// the sweep is done. A clear item repeats the sweep and then replies. A release
// steps through accept, RAM read, write back and reply. An allocate takes the
// same steps plus a RAM read and a check for every full word it steps over; a
// low-water mark of the first word that may hold a free bit keeps that walk
// short, and a release below the mark pulls it back. The block takes one item at
// a time; base_id is written through its own port, which the user must do only
// while the block is idle; the block itself does not enforce this.
module first_free_id_allocator
   import ffid_pkg::*;
#(
   parameter int ID_COUNT = ID_COUNT_DEF
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_tvalid,
   output logic            req_tready,
   input  logic [ID_W-1:0] req_tdata,   // id_in
   input  logic [1:0]      req_tuser,   // cmd
   output logic            rsp_tvalid,
   input  logic            rsp_tready,
   output logic [ID_W-1:0] rsp_tdata,   // id_out
   output logic [1:0]      rsp_tuser,   // status
   input  logic            csr_valid,
   output logic            csr_ready,
   input  logic [ID_W-1:0] csr_wdata    // base_id
);

   localparam int NWORDS   = (ID_COUNT + WORD_W - 1) / WORD_W;
   localparam int ADDR_W   = (NWORDS > 1) ? $clog2(NWORDS) : 1;
   localparam int HINT_W   = $clog2(NWORDS + 1);
   localparam int LAST_PAD = NWORDS * WORD_W - ID_COUNT;
   localparam logic [WORD_W-1:0] PAD_MASK = ~({WORD_W{1'b1}} >> LAST_PAD);
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(NWORDS - 1);
   localparam logic [HINT_W-1:0] HINT_END = HINT_W'(NWORDS);

   typedef enum logic [4:0] {
      S_SWEEP  = 5'b00001,
      S_IDLE   = 5'b00010,
      S_READ   = 5'b00100,
      S_MODIFY = 5'b01000,
      S_REPLY  = 5'b10000
   } state_type;

   state_type         state_ff, state_in;
   logic [1:0]        cmd_ff, cmd_in;
   logic [ID_W-1:0]   off_ff, off_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic [HINT_W-1:0] hint_ff, hint_in;
   logic              sweep_cmd_ff, sweep_cmd_in;
   logic [1:0]        res_status_ff, res_status_in;
   logic [ID_W-1:0]   res_id_ff, res_id_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [1:0]        rsp_status_ff, rsp_status_in;
   logic [ID_W-1:0]   rsp_id_ff, rsp_id_in;
   logic [ID_W-1:0]   base_ff, base_in;

   logic              ram_we;
   logic [WORD_W-1:0] ram_wdata;
   logic [WORD_W-1:0] ram_rdata;
   logic [WORD_W-1:0] eff_word;
   ffid_find_type     find;

   logic [ID_W-1:0]   req_off;
   logic              req_in_pool;
   logic [HINT_W-1:0] hint_next;
   logic [ADDR_W-1:0] rel_addr;
   logic [ADDR_W+BIT_W-1:0] alloc_pos;
   logic              req_fire;

   ffid_ram #(
      .WIDTH (WORD_W),
      .DEPTH (NWORDS)
   ) u_map (
      .clock (clock),
      .we    (ram_we),
      .addr  (addr_ff),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   assign eff_word = ram_rdata | ((addr_ff == LAST_ADDR) ? PAD_MASK : '0);

   ffid_find u_find (
      .word   (eff_word),
      .result (find)
   );

   assign req_tready  = (state_ff == S_IDLE);
   assign req_fire    = req_tvalid && req_tready;
   assign req_off     = req_tdata - base_ff;
   assign req_in_pool = ({1'b0, req_off} < 17'(ID_COUNT));
   assign hint_next   = hint_ff + HINT_W'(1);
   assign rel_addr    = off_ff[ADDR_W+BIT_W-1:BIT_W];
   assign alloc_pos   = {addr_ff, find.idx};

   assign csr_ready = 1'b1;
   assign base_in   = (csr_valid && csr_ready) ? csr_wdata : base_ff;

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      off_in        = off_ff;
      addr_in       = addr_ff;
      hint_in       = hint_ff;
      sweep_cmd_in  = sweep_cmd_ff;
      res_status_in = res_status_ff;
      res_id_in     = res_id_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_id_in     = rsp_id_ff;
      ram_we        = 1'b0;
      ram_wdata     = '0;

      unique case (state_ff)
         S_SWEEP: begin
            ram_we = 1'b1;
            if (addr_ff == LAST_ADDR) begin
               hint_in  = '0;
               state_in = sweep_cmd_ff ? S_REPLY : S_IDLE;
            end else begin
               addr_in = addr_ff + ADDR_W'(1);
            end
         end
         S_IDLE: begin
            if (req_fire) begin
               cmd_in        = req_tuser;
               off_in        = req_off;
               res_status_in = ST_OK;
               res_id_in     = '0;
               unique case (req_tuser)
                  CMD_CLEAR: begin
                     addr_in      = '0;
                     sweep_cmd_in = 1'b1;
                     state_in     = S_SWEEP;
                  end
                  CMD_ALLOC: begin
                     if (hint_ff == HINT_END) begin
                        res_status_in = ST_NONE_FREE;
                        state_in      = S_REPLY;
                     end else begin
                        addr_in  = hint_ff[ADDR_W-1:0];
                        state_in = S_READ;
                     end
                  end
                  CMD_RELEASE: begin
                     if (req_in_pool) begin
                        addr_in  = req_off[ADDR_W+BIT_W-1:BIT_W];
                        state_in = S_READ;
                     end else begin
                        res_status_in = ST_INVALID;
                        state_in      = S_REPLY;
                     end
                  end
                  default: begin
                     state_in = S_REPLY;
                  end
               endcase
            end
         end
         S_READ: begin
            state_in = S_MODIFY;
         end
         S_MODIFY: begin
            if (cmd_ff == CMD_ALLOC) begin
               if (find.found) begin
                  ram_we    = 1'b1;
                  ram_wdata = ram_rdata | find.onehot;
                  res_id_in = base_ff + ID_W'(alloc_pos);
                  if (find.full_after) begin
                     hint_in = hint_next;
                  end
                  state_in = S_REPLY;
               end else begin
                  hint_in = hint_next;
                  if (hint_next == HINT_END) begin
                     res_status_in = ST_NONE_FREE;
                     state_in      = S_REPLY;
                  end else begin
                     addr_in  = hint_next[ADDR_W-1:0];
                     state_in = S_READ;
                  end
               end
            end else begin
               ram_we    = 1'b1;
               ram_wdata = ram_rdata & ~(WORD_W'(1) << off_ff[BIT_W-1:0]);
               if (HINT_W'(rel_addr) < hint_ff) begin
                  hint_in = HINT_W'(rel_addr);
               end
               state_in = S_REPLY;
            end
         end
         S_REPLY: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_id_in     = res_id_ff;
               sweep_cmd_in  = 1'b0;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_SWEEP;
         addr_ff      <= '0;
         hint_ff      <= '0;
         sweep_cmd_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         base_ff      <= BASE_RESET;
      end else begin
         state_ff     <= state_in;
         addr_ff      <= addr_in;
         hint_ff      <= hint_in;
         sweep_cmd_ff <= sweep_cmd_in;
         rsp_valid_ff <= rsp_valid_in;
         base_ff      <= base_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      off_ff        <= off_in;
      res_status_ff <= res_status_in;
      res_id_ff     <= res_id_in;
      rsp_status_ff <= rsp_status_in;
      rsp_id_ff     <= rsp_id_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_id_ff;
   assign rsp_tuser  = rsp_status_ff;

`ifndef SYNTHESIS
   a_hint_bound: assert property (@(posedge clock) disable iff (reset)
      hint_ff <= HINT_END)
      else $error("low-water mark passed the end of the bitmap");

   a_alloc_at_hint: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MODIFY) && (cmd_ff == CMD_ALLOC) |-> addr_ff == hint_ff[ADDR_W-1:0])
      else $error("allocate inspected a word other than the low-water mark");

   a_reply_loads: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_REPLY) && (!rsp_valid_ff || rsp_tready)
         |=> rsp_tvalid && (state_ff == S_IDLE))
      else $error("reply was not moved to the output register");

   a_fail_zero_id: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != ST_OK) |-> rsp_tdata == '0)
      else $error("failed item carries a nonzero identifier");
`endif

endmodule
